// ===== rtl/rlm_pkg.sv =====
// shared types and constants for the rms level meter
`timescale 1ns / 1ps

package rlm_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SQ_W        = 2 * SAMPLE_W;
    localparam int FRAC_SHIFT  = 8;
    localparam int MSQ_W       = 32;
    localparam int RMS_W       = 16;
    localparam int LEVEL_W     = 8;
    localparam int STEP_W      = 16;

    localparam logic [STEP_W-1:0]  STEP_RESET = 16'd16;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
    localparam logic [RMS_W-1:0]   RMS_MAX    = 16'd65520;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } in_word_t;

    typedef struct packed {
        logic [RMS_W-1:0]   rms;
        logic [LEVEL_W-1:0] level;
        logic               overflow;
    } out_word_t;

    typedef struct packed {
        logic acc;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic lvl_load;
        logic lvl_step;
        logic out_load;
    } cmd_t;

endpackage

// ===== rtl/rms_level_meter_unit.sv =====
// top level of the rms level meter
//
//  channel  direction  word        handshake
//  s_       in         in_word_t   s_valid / s_ready
//  m_       out        out_word_t  m_valid / m_ready
//  cfg_     in         level_step  cfg_wr_en, no wait
//
// samples go in one per cycle while s_ready is high, squared and summed into a register
// a last word starts the frame-end sequence: the shift-subtract divider runs one
// bit per cycle over 24 + clog2(MAX_SAMPLES+1) + 8 bits, then the root is loaded
// and stepped, the level division likewise, and then the output register loaded
// s_ready is low during that sequence; the result sits in an output register,
// so the next frame is taken while it waits on m_ready; a second finished frame
// holds s_ready low until that register is taken
// synchronous active-low reset clears the accumulators and sets level_step to 16
`timescale 1ns / 1ps

module rms_level_meter_unit
    import rlm_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_word,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_word,
    input  logic              cfg_wr_en,
    input  logic [STEP_W-1:0] cfg_wr_data
);

    cmd_t cmd;

    rlm_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_word.last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    rlm_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_word      (s_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_word      (m_word)
    );

endmodule

// ===== rtl/rlm_datapath.sv =====
// accumulators, shift-subtract divider, square root and level divider
`timescale 1ns / 1ps

module rlm_datapath
    import rlm_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    input  in_word_t            s_word,
    input  logic                cfg_wr_en,
    input  logic [STEP_W-1:0]   cfg_wr_data,
    output out_word_t           m_word
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SQ_W + CNT_W;
    localparam int NUM_W = SUM_W + FRAC_SHIFT;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic              ovf_hold_reg;
    logic [SQ_W-1:0]   sq;

    // frame divider: numerator shifts out, quotient shifts in
    logic [NUM_W-1:0]  div_q_reg;
    logic [CNT_W-1:0]  div_den_reg;
    logic [CNT_W-1:0]  div_rem_reg, div_rem_next;
    logic [CNT_W:0]    div_trial, div_diff;
    logic              div_ge;

    // square root, two operand bits per step
    logic [MSQ_W-1:0]  sq_op_reg;
    logic [RMS_W+1:0]  sq_rem_reg, sq_rem_next;
    logic [RMS_W-1:0]  root_reg;
    logic [RMS_W+3:0]  sq_trial_rem, sq_trial, sq_diff;
    logic              sq_ge;

    // level divider
    logic [RMS_W-1:0]  lvl_q_reg;
    logic [STEP_W-1:0] lvl_rem_reg, lvl_rem_next;
    logic [STEP_W:0]   lvl_trial, lvl_diff;
    logic              lvl_ge;
    logic [LEVEL_W-1:0] level;

    assign sq = s_word.sample * s_word.sample;

    always_comb begin
        if (cnt_reg < CNT_MAX) begin
            sum_next = sum_reg + SUM_W'(sq);
            cnt_next = cnt_reg + 1'b1;
            ovf_next = ovf_reg;
        end else begin
            sum_next = sum_reg;
            cnt_next = cnt_reg;
            ovf_next = 1'b1;
        end
    end

    assign div_trial = {div_rem_reg, div_q_reg[NUM_W-1]};
    assign div_diff  = div_trial - {1'b0, div_den_reg};
    assign div_ge    = (div_trial >= {1'b0, div_den_reg});
    assign div_rem_next = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];

    assign sq_trial_rem = {sq_rem_reg, sq_op_reg[MSQ_W-1:MSQ_W-2]};
    assign sq_trial     = {2'b00, root_reg, 2'b01};
    assign sq_diff      = sq_trial_rem - sq_trial;
    assign sq_ge        = (sq_trial_rem >= sq_trial);
    assign sq_rem_next  = sq_ge ? sq_diff[RMS_W+1:0] : sq_trial_rem[RMS_W+1:0];

    assign lvl_trial = {lvl_rem_reg, lvl_q_reg[RMS_W-1]};
    assign lvl_diff  = lvl_trial - {1'b0, step_reg};
    assign lvl_ge    = (lvl_trial >= {1'b0, step_reg});
    assign lvl_rem_next = lvl_ge ? lvl_diff[STEP_W-1:0] : lvl_trial[STEP_W-1:0];

    // a zero step gives an all-ones quotient, which saturates as required
    always_comb begin
        if (root_reg == '0) begin
            level = '0;
        end else if (lvl_q_reg > RMS_W'(LEVEL_MAX)) begin
            level = LEVEL_MAX;
        end else begin
            level = lvl_q_reg[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            if (cmd.acc) begin
                if (s_word.last) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end else begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc && s_word.last) begin
            div_q_reg    <= {sum_next, FRAC_SHIFT'(0)};
            div_den_reg  <= cnt_next;
            div_rem_reg  <= '0;
            ovf_hold_reg <= ovf_next;
        end else if (cmd.div_step) begin
            div_q_reg   <= {div_q_reg[NUM_W-2:0], div_ge};
            div_rem_reg <= div_rem_next;
        end

        if (cmd.sqrt_load) begin
            sq_op_reg  <= div_q_reg[MSQ_W-1:0];
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end else if (cmd.sqrt_step) begin
            sq_op_reg  <= {sq_op_reg[MSQ_W-3:0], 2'b00};
            sq_rem_reg <= sq_rem_next;
            root_reg   <= {root_reg[RMS_W-2:0], sq_ge};
        end

        if (cmd.lvl_load) begin
            lvl_q_reg   <= root_reg - 1'b1;
            lvl_rem_reg <= '0;
        end else if (cmd.lvl_step) begin
            lvl_q_reg   <= {lvl_q_reg[RMS_W-2:0], lvl_ge};
            lvl_rem_reg <= lvl_rem_next;
        end

        if (cmd.out_load) begin
            m_word.rms      <= root_reg;
            m_word.level    <= level;
            m_word.overflow <= ovf_hold_reg;
        end
    end

endmodule

// ===== rtl/rlm_ctrl.sv =====
// sequencer for sample intake and the end-of-frame divide, root and level passes
`timescale 1ns / 1ps

module rlm_ctrl
    import rlm_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_last,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int NUM_W  = SQ_W + CNT_W + FRAC_SHIFT;
    localparam int ITER_W = $clog2(NUM_W);
    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(NUM_W - 1);
    localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(RMS_W - 1);
    localparam logic [ITER_W-1:0] LVL_LAST  = ITER_W'(RMS_W - 1);

    localparam logic [2:0] ST_ACC  = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SQLD = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_LVLD = 3'd4;
    localparam logic [2:0] ST_LVL  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign s_ready  = (state_reg == ST_ACC);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_ACC: begin
                cmd.acc = s_valid;
                if (s_valid && s_last) begin
                    state_next = ST_DIV;
                    iter_next  = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == DIV_LAST) begin
                    state_next = ST_SQLD;
                end
            end
            ST_SQLD: begin
                cmd.sqrt_load = 1'b1;
                iter_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                iter_next     = iter_reg + 1'b1;
                if (iter_reg == ROOT_LAST) begin
                    state_next = ST_LVLD;
                end
            end
            ST_LVLD: begin
                cmd.lvl_load = 1'b1;
                iter_next    = '0;
                state_next   = ST_LVL;
            end
            ST_LVL: begin
                cmd.lvl_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == LVL_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the finished word until the output register frees up
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/rlm_checker.sv =====
// port-level checks for the rms level meter, bound to the top level
`timescale 1ns / 1ps

module rlm_checker
    import rlm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_word,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // frame end stops intake for the divide, root and level passes
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_word.last |=> !s_ready)
        else $error("input still ready after last word");

    // zero rms always reports level zero
    a_zero_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_word.rms == '0) |-> (m_word.level == '0))
        else $error("nonzero level with zero rms");

    // rms of 12-bit samples cannot exceed full scale
    a_rms_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.rms <= RMS_MAX))
        else $error("rms above full scale");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rms_level_meter_unit rlm_checker u_rlm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_word  (s_word),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
